/* rtl/stff_pkg.sv */
// ----------------------------------------------------------------------------
// stff_pkg: shared types and constants of the Sobel tangent flow field block
// Geometry limits, fixed-point sizes, sequencer states, register indexes and
// the raster position wrap helper.
// ----------------------------------------------------------------------------
`default_nettype none

package stff_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int VEC_FRAC_BITS = 14;

	localparam int COL_W = $clog2(MAX_WIDTH);   // column index bits
	localparam int WID_W = COL_W + 1;           // holds the width itself
	localparam int HGT_W = $clog2(MAX_HEIGHT) + 1;

	// make-unit datapath sizes
	localparam int MAG_W = 31;                      // magnitude, up to 2^30
	localparam int SQ_W  = 60;                      // square of a 30-bit magnitude
	localparam int SUM_W = 61;                      // sum of two squares
	localparam int QUO_W = 2 * VEC_FRAC_BITS + 3;   // quotient, up to 2^(2F+2)
	localparam int RT_W  = VEC_FRAC_BITS + 2;       // root, up to 2^(F+1)

	// register indexes of the configuration port
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_FLOW_STRENGTH = 3'd2;
	localparam logic [2:0] REG_DEFAULT_DX    = 3'd3;
	localparam logic [2:0] REG_DEFAULT_DY    = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,   // wait for an item
		ST_WIN,    // line memory data back: window, gradient, emit decision
		ST_NORM,   // scale magnitudes below 2^30
		ST_SQX,    // x magnitude squared
		ST_SQY,    // y magnitude squared
		ST_SUM,    // sum of squares, start first divide
		ST_DIV,    // restoring divide, one quotient bit a cycle
		ST_SQRT,   // integer root, one result bit a cycle
		ST_NEXT,   // round one component, start the other
		ST_FLIP,   // orient tangent along the default direction
		ST_BLEND,  // blend tangent with the default direction
		ST_OUT     // hand result to output register
	} state_t;

	typedef struct packed {
		logic [WID_W-1:0] col;
		logic [HGT_W-1:0] row;
	} pos_t;

	// Wrap a raster position that lies at or past the frame size.
	function automatic pos_t wrap_pos(pos_t p, logic [WID_W-1:0] w, logic [HGT_W-1:0] h);
		pos_t r;
		r = p;
		if (r.col >= w) begin
			r.col = '0;
			r.row = r.row + 1'b1;
		end
		if (r.row >= h) begin
			r.row = '0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/stff_ram.sv */
// ----------------------------------------------------------------------------
// stff_ram: generic single-port synchronous RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

/* rtl/sobel_tangent_flow_field_top.sv */
// ----------------------------------------------------------------------------
// sobel_tangent_flow_field_top: Sobel edge tangent direction field
// Streams grey pixels in raster order, emits one unit direction per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item: a pixel (command 0)
//   or a flush tick (command 1). Output channel (out_valid/out_stall) carries
//   the direction vector in Q1.14 with its column, row and end-of-frame flag.
//   Results lag the pixels by width items; flush ticks drain the remainder.
//   One item at a time is processed. A border or weak-gradient result
//   takes at most one make-unit pass, an edge result at most two (the
//   tangent, then its blend, halved first while oversized): each make-unit
//   pass runs a restoring divider and an integer root per component on one
//   shared sequencer. Both line stores live in one 16-bit wide line memory.
//   Reset clears position counters, window and backlog and loads register
//   defaults; the line memory is not cleared. A finished result waits in the
//   output register while the next item is accepted; a new result waits in
//   ST_OUT until the output register is free, holding in_stall high.
//   Configuration writes must be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_tangent_flow_field_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	// input items
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [7:0]         pixel_value,
	// result items
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      flow_x,
	output logic signed [15:0]      flow_y,
	output logic [stff_pkg::COL_W-1:0] out_col,
	output logic [11:0]             out_row,
	output logic                    last_of_frame
);

	import stff_pkg::*;

	// configuration registers
	logic [10:0]        fw_q;
	logic [12:0]        fh_q;
	logic [15:0]        fs_q;
	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;

	// sequencer and position state
	state_t             state_q, state_d;
	pos_t               in_pos_q, em_pos_q;
	logic [10:0]        backlog_q;
	logic [7:0]         win_q [6];
	logic               cmd_q;
	logic [7:0]         pix_q;
	logic signed [11:0] gx_q, gy_q;
	logic               phase_q, comp_q;
	logic [4:0]         cnt_q;
	logic [COL_W-1:0]   hc_q;
	logic [11:0]        hr_q;
	logic               hl_q;

	// make-unit datapath
	logic signed [31:0] vx_q, vy_q;
	logic [MAG_W-1:0]   ux_q, uy_q;
	logic [SQ_W-1:0]    sx_q, sy_q;
	logic [SUM_W-1:0]   s_q, rem_q;
	logic [QUO_W-1:0]   nb_q, quo_q;
	logic [31:0]        op_q, res_q, one_q;
	logic signed [15:0] rx_q, ry_q;

	// line memory
	logic               ram_we;
	logic [COL_W-1:0]   ram_addr;
	logic [15:0]        ram_rdata;

	function automatic logic [MAG_W-1:0] mag(logic signed [31:0] v);
		logic [31:0] a;
		a = v[31] ? 32'(-v) : 32'(v);
		return a[MAG_W-1:0];
	endfunction

	function automatic logic signed [11:0] s12(logic [7:0] v);
		return $signed({4'b0, v});
	endfunction

	// effective geometry and strength
	logic [WID_W-1:0] eff_w;
	logic [HGT_W-1:0] eff_h;
	logic [15:0]      fs_eff, inv_w;

	always_comb begin
		if (fw_q == '0) eff_w = WID_W'(1);
		else if (fw_q > WID_W'(MAX_WIDTH)) eff_w = WID_W'(MAX_WIDTH);
		else eff_w = fw_q;
		if (fh_q == '0) eff_h = HGT_W'(1);
		else if (fh_q > HGT_W'(MAX_HEIGHT)) eff_h = HGT_W'(MAX_HEIGHT);
		else eff_h = fh_q;
		fs_eff = (fs_q > 16'd32768) ? 16'd32768 : fs_q;
		inv_w  = 16'd32768 - fs_eff;
	end

	// positions at accept time
	pos_t in_wrap, em_wrap, in_next, em_next;

	always_comb begin
		in_wrap = wrap_pos(in_pos_q, eff_w, eff_h);
		em_wrap = wrap_pos(em_pos_q, eff_w, eff_h);
		in_next = wrap_pos('{col: in_pos_q.col + 1'b1, row: in_pos_q.row}, eff_w, eff_h);
		em_next = wrap_pos('{col: em_pos_q.col + 1'b1, row: em_pos_q.row}, eff_w, eff_h);
	end

	// window gradient and emit decision
	logic [7:0]         up_c, mid_c;
	logic signed [11:0] gx_c, gy_c;
	logic signed [23:0] gmag_c;
	logic [10:0]        blog_inc;
	logic               emit_c, interior_c;

	always_comb begin
		up_c   = ram_rdata[15:8];
		mid_c  = ram_rdata[7:0];
		gx_c   = s12(up_c) + (s12(mid_c) <<< 1) + s12(pix_q)
		       - s12(win_q[0]) - (s12(win_q[1]) <<< 1) - s12(win_q[2]);
		gy_c   = s12(win_q[2]) + (s12(win_q[5]) <<< 1) + s12(pix_q)
		       - s12(win_q[0]) - (s12(win_q[3]) <<< 1) - s12(up_c);
		gmag_c = 24'(gx_c) * 24'(gx_c) + 24'(gy_c) * 24'(gy_c);
		blog_inc = backlog_q + 1'b1;
		emit_c = cmd_q ? (backlog_q != '0) : (blog_inc > eff_w);
		interior_c = !cmd_q && (em_pos_q.row >= HGT_W'(1))
		          && ((em_pos_q.row + 1'b1) < eff_h)
		          && (em_pos_q.col >= WID_W'(1))
		          && ((em_pos_q.col + 1'b1) < eff_w)
		          && (gmag_c > 24'sd25);
	end

	// divider and root steps
	logic [SUM_W:0]     rem2_c, sub_c;
	logic               ge_c;
	logic [QUO_W-1:0]   quo_n;
	logic [31:0]        sq_t;
	logic               sq_ge;
	logic [15:0]        q_c;
	logic signed [29:0] dot_c;
	logic signed [32:0] bx_c, by_c;

	always_comb begin
		rem2_c = {rem_q, nb_q[QUO_W-1]};
		sub_c  = rem2_c - {1'b0, s_q};
		ge_c   = rem2_c >= {1'b0, s_q};
		quo_n  = {quo_q[QUO_W-2:0], ge_c};
		sq_t   = res_q + one_q;
		sq_ge  = op_q >= sq_t;
		q_c    = 16'((17'(res_q[RT_W-1:0]) + 17'd1) >> 1);
		dot_c  = 30'(gx_q) * 30'(dy_q) - 30'(gy_q) * 30'(dx_q);
		bx_c   = $signed({17'b0, fs_eff}) * 33'(rx_q) + $signed({17'b0, inv_w}) * 33'(dx_q);
		by_c   = $signed({17'b0, fs_eff}) * 33'(ry_q) + $signed({17'b0, inv_w}) * 33'(dy_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_WIN;
			ST_WIN:   state_d = emit_c ? ST_NORM : ST_IDLE;
			ST_NORM: begin
				if (ux_q == '0 && uy_q == '0) state_d = phase_q ? ST_OUT : ST_FLIP;
				else if (!(ux_q[MAG_W-1] || uy_q[MAG_W-1])) state_d = ST_SQX;
			end
			ST_SQX:   state_d = ST_SQY;
			ST_SQY:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DIV;
			ST_DIV:   if (cnt_q == '0) state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == '0) state_d = ST_NEXT;
			ST_NEXT: begin
				if (!comp_q) state_d = ST_DIV;
				else state_d = phase_q ? ST_OUT : ST_FLIP;
			end
			ST_FLIP:  state_d = ST_BLEND;
			ST_BLEND: state_d = ST_NORM;
			ST_OUT:   if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		ram_we   = (state_q == ST_WIN) && !cmd_q;
		ram_addr = (state_q == ST_WIN) ? in_pos_q.col[COL_W-1:0] : in_wrap.col[COL_W-1:0];
	end

	stff_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({mid_c, pix_q}),
		.rdata (ram_rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd640;
			fh_q <= 13'd480;
			fs_q <= 16'd16384;
			dx_q <= 16'sd16384;
			dy_q <= 16'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   fw_q <= cfg_data[10:0];
				REG_FRAME_HEIGHT:  fh_q <= cfg_data[12:0];
				REG_FLOW_STRENGTH: fs_q <= cfg_data;
				REG_DEFAULT_DX:    dx_q <= $signed(cfg_data);
				REG_DEFAULT_DY:    dy_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_pos_q  <= '0;
			em_pos_q  <= '0;
			backlog_q <= '0;
			win_q     <= '{default: '0};
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			// output register: load from hand-off state, else drop when taken
			if (state_q == ST_OUT && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						em_pos_q <= em_wrap;
						if (!command) in_pos_q <= in_wrap;
					end
				end
				ST_WIN: begin
					if (!cmd_q) begin
						win_q[0] <= win_q[3];
						win_q[1] <= win_q[4];
						win_q[2] <= win_q[5];
						win_q[3] <= up_c;
						win_q[4] <= mid_c;
						win_q[5] <= pix_q;
						in_pos_q <= in_next;
						if (!emit_c) backlog_q <= blog_inc;
					end else if (emit_c) begin
						backlog_q <= backlog_q - 1'b1;
					end
					if (emit_c) em_pos_q <= em_next;
				end
				default: ;
			endcase
		end
	end

	// payload and datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= command;
				pix_q <= pixel_value;
			end
			ST_WIN: begin
				gx_q <= gx_c;
				gy_q <= gy_c;
				hc_q <= em_pos_q.col[COL_W-1:0];
				hr_q <= em_pos_q.row[11:0];
				hl_q <= (em_pos_q.row == eff_h - 1'b1) && (em_pos_q.col == eff_w - 1'b1);
				if (interior_c) begin
					vx_q    <= -32'(gy_c);
					vy_q    <= 32'(gx_c);
					ux_q    <= mag(-32'(gy_c));
					uy_q    <= mag(32'(gx_c));
					phase_q <= 1'b0;
				end else begin
					vx_q    <= 32'(dx_q);
					vy_q    <= 32'(dy_q);
					ux_q    <= mag(32'(dx_q));
					uy_q    <= mag(32'(dy_q));
					phase_q <= 1'b1;
				end
			end
			ST_NORM: begin
				if (ux_q == '0 && uy_q == '0) begin
					rx_q <= '0;
					ry_q <= '0;
				end else if (ux_q[MAG_W-1] || uy_q[MAG_W-1]) begin
					ux_q <= ux_q >> 1;
					uy_q <= uy_q >> 1;
				end
			end
			ST_SQX: sx_q <= ux_q[MAG_W-2:0] * ux_q[MAG_W-2:0];
			ST_SQY: sy_q <= uy_q[MAG_W-2:0] * uy_q[MAG_W-2:0];
			ST_SUM: begin
				s_q    <= SUM_W'(sx_q) + SUM_W'(sy_q);
				comp_q <= 1'b0;
				rem_q  <= SUM_W'(sx_q >> 1);
				nb_q   <= {sx_q[0], {(QUO_W-1){1'b0}}};
				quo_q  <= '0;
				cnt_q  <= 5'(QUO_W - 1);
			end
			ST_DIV: begin
				rem_q <= ge_c ? sub_c[SUM_W-1:0] : rem2_c[SUM_W-1:0];
				nb_q  <= nb_q << 1;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					op_q  <= 32'(quo_n);
					res_q <= '0;
					one_q <= 32'h4000_0000;
					cnt_q <= 5'(RT_W - 1);
				end
			end
			ST_SQRT: begin
				if (sq_ge) begin
					op_q  <= op_q - sq_t;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_NEXT: begin
				if (!comp_q) begin
					rx_q   <= vx_q[31] ? -q_c : q_c;
					comp_q <= 1'b1;
					rem_q  <= SUM_W'(sy_q >> 1);
					nb_q   <= {sy_q[0], {(QUO_W-1){1'b0}}};
					quo_q  <= '0;
					cnt_q  <= 5'(QUO_W - 1);
				end else begin
					ry_q <= vy_q[31] ? -q_c : q_c;
				end
			end
			ST_FLIP: begin
				if (dot_c < 0) begin
					rx_q <= -rx_q;
					ry_q <= -ry_q;
				end
			end
			ST_BLEND: begin
				vx_q    <= 32'(bx_c);
				vy_q    <= 32'(by_c);
				ux_q    <= mag(32'(bx_c));
				uy_q    <= mag(32'(by_c));
				phase_q <= 1'b1;
			end
			ST_OUT: begin
				if (!out_valid || !out_stall) begin
					flow_x        <= rx_q;
					flow_y        <= ry_q;
					out_col       <= hc_q;
					out_row       <= hr_q;
					last_of_frame <= hl_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_backlog_bound: assert property (@(posedge clk) disable iff (!arst_n)
		backlog_q <= 11'd1025)
		else $error("backlog above width plus one");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (flow_x <= 16'sd16384 && flow_x >= -16'sd16384
		            && flow_y <= 16'sd16384 && flow_y >= -16'sd16384))
		else $error("result vector component out of range");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result loaded outside hand-off state");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> s_q != '0)
		else $error("divide by zero sum of squares");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NEXT |-> res_q <= 32'd32768)
		else $error("root exceeds unit scale");

endmodule

`default_nettype wire

/* dv/stff_tb_pkg.sv */
// ----------------------------------------------------------------------------
// stff_tb_pkg: testbench constants of the Sobel tangent flow field bench
// Input item command codes, shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package stff_tb_pkg;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

endpackage

/* dv/stff_flow_checker.sv */
// ----------------------------------------------------------------------------
// stff_flow_checker: predicts and checks the flow direction stream
// Watches the configuration port and both channels, runs its own Sobel
// window and fixed-point direction predictor on every accepted input item,
// and compares each accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module stff_flow_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic [7:0]         pixel_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] flow_x,
	input  logic signed [15:0] flow_y,
	input  logic [9:0]         out_col,
	input  logic [11:0]        out_row,
	input  logic               last_of_frame,
	output int                 mismatches,
	output int                 vectors_due,
	output int                 vectors_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import stff_pkg::*;
	import stff_tb_pkg::*;

	typedef struct {
		logic [15:0] fx;
		logic [15:0] fy;
		logic [9:0]  col;
		logic [11:0] row;
		logic        last;
	} flow_vec_t;

	flow_vec_t vec_due_q[$];

	// predictor copy of registers and pipeline state
	logic [10:0] cur_width;
	logic [12:0] cur_height;
	logic [15:0] cur_strength, cur_dx, cur_dy;
	logic [7:0]  row_above[MAX_WIDTH];
	logic [7:0]  row_prev[MAX_WIDTH];
	logic [7:0]  win_cols[6];
	int          pix_col, pix_row, vec_col, vec_row, pixels_owed;

	assign vectors_due = vec_due_q.size();

	// round(a * 2^F / sqrt(s)) by search on the exact squared inequality
	function automatic longint unsigned unit_share(longint unsigned a, longint unsigned s);
		logic [127:0] lim, prod;
		longint unsigned lo, hi, m, t;
		lim = 128'(a * a) << (2 * VEC_FRAC_BITS + 2);
		lo = 0;
		hi = 64'd1 << VEC_FRAC_BITS;
		while (lo < hi) begin
			m = (lo + hi + 1) / 2;
			t = 2 * m - 1;
			prod = 128'(t * t) * 128'(s);
			if (prod <= lim) lo = m;
			else hi = m - 1;
		end
		return lo;
	endfunction

	function automatic void to_unit(input longint x, input longint y,
		output longint ox, output longint oy);
		longint unsigned ux, uy, s;
		ux = (x < 0) ? -x : x;
		uy = (y < 0) ? -y : y;
		if (ux == 0 && uy == 0) begin
			ox = 0;
			oy = 0;
			return;
		end
		while (ux >= (64'd1 << 30) || uy >= (64'd1 << 30)) begin
			ux = ux >> 1;
			uy = uy >> 1;
		end
		s = ux * ux + uy * uy;
		ox = unit_share(ux, s);
		oy = unit_share(uy, s);
		if (x < 0) ox = -ox;
		if (y < 0) oy = -oy;
	endfunction

	function automatic void wrap_at(inout int c, inout int r, input int w, input int h);
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h) r = 0;
	endfunction

	// one input item through the window and direction predictor
	task automatic predict_flow(input logic cmd, input logic [7:0] p);
		int w, h;
		longint dx, dy, fs, gx, gy, tl, ml, bl, tc, bc, up, mid, tx, ty, fx, fy;
		bit windowed;
		flow_vec_t v;
		w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH ? MAX_WIDTH : cur_width);
		h = (cur_height == 0) ? 1 : (cur_height > MAX_HEIGHT ? MAX_HEIGHT : cur_height);
		dx = longint'($signed(cur_dx));
		dy = longint'($signed(cur_dy));
		fs = (cur_strength > 32768) ? 32768 : cur_strength;
		gx = 0;
		gy = 0;
		windowed = 0;
		wrap_at(vec_col, vec_row, w, h);
		if (cmd == CMD_PIXEL) begin
			wrap_at(pix_col, pix_row, w, h);
			up  = row_above[pix_col];
			mid = row_prev[pix_col];
			tl = win_cols[0]; ml = win_cols[1]; bl = win_cols[2];
			tc = win_cols[3]; bc = win_cols[5];
			gx = -tl - 2 * ml - bl + up + 2 * mid + p;
			gy = -tl - 2 * tc - up + bl + 2 * bc + p;
			win_cols[0:2] = win_cols[3:5];
			win_cols[3] = up;
			win_cols[4] = mid;
			win_cols[5] = p;
			row_above[pix_col] = mid;
			row_prev[pix_col] = p;
			pix_col++;
			wrap_at(pix_col, pix_row, w, h);
			pixels_owed++;
			if (pixels_owed <= w) return;
			windowed = 1;
		end else if (pixels_owed == 0) begin
			return;
		end
		pixels_owed--;
		if (windowed && vec_row >= 1 && vec_row + 1 < h && vec_col >= 1 && vec_col + 1 < w
			&& gx * gx + gy * gy > 25) begin
			to_unit(-gy, gx, tx, ty);
			if ((-gy) * dx + gx * dy < 0) begin
				tx = -tx;
				ty = -ty;
			end
			to_unit(fs * tx + (32768 - fs) * dx, fs * ty + (32768 - fs) * dy, fx, fy);
		end else begin
			to_unit(dx, dy, fx, fy);
		end
		v.fx = fx[15:0];
		v.fy = fy[15:0];
		v.col = vec_col[9:0];
		v.row = vec_row[11:0];
		v.last = (vec_row == h - 1 && vec_col == w - 1);
		vec_due_q = {vec_due_q, v};
		vec_col++;
		wrap_at(vec_col, vec_row, w, h);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		vectors_checked = 0;
		foreach (row_above[i]) row_above[i] = '0;
		foreach (row_prev[i]) row_prev[i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		flow_vec_t e;
		if (!arst_n) begin
			cur_width = 11'd640;
			cur_height = 13'd480;
			cur_strength = 16'd16384;
			cur_dx = 16'd16384;
			cur_dy = 16'd0;
			foreach (win_cols[i]) win_cols[i] = '0;
			pix_col = 0; pix_row = 0; vec_col = 0; vec_row = 0; pixels_owed = 0;
			vec_due_q.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:   cur_width = cfg_data[10:0];
					REG_FRAME_HEIGHT:  cur_height = cfg_data[12:0];
					REG_FLOW_STRENGTH: cur_strength = cfg_data;
					REG_DEFAULT_DX:    cur_dx = cfg_data;
					REG_DEFAULT_DY:    cur_dy = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) predict_flow(command, pixel_value);
			// result compare
			if (out_valid && !out_stall) begin
				if (vec_due_q.size() == 0) begin
					$display("[%0t] unexpected vector at col %0d row %0d",
						$realtime, out_col, out_row);
					mismatches++;
				end else begin
					e = vec_due_q.pop_front();
					vectors_checked++;
					if (flow_x !== e.fx) flag_mismatch("flow_x", flow_x, $signed(e.fx));
					if (flow_y !== e.fy) flag_mismatch("flow_y", flow_y, $signed(e.fy));
					if (out_col !== e.col) flag_mismatch("out_col", out_col, e.col);
					if (out_row !== e.row) flag_mismatch("out_row", out_row, e.row);
					if (last_of_frame !== e.last)
						flag_mismatch("last_of_frame", last_of_frame, e.last);
				end
			end
		end
	end

endmodule

/* dv/sobel_tangent_flow_field_top_tb.sv */
// ----------------------------------------------------------------------------
// sobel_tangent_flow_field_top_tb: stimulus and verdict for the flow field
// Streams small frames of edges, ramps, flat areas and noise under several
// geometries, strengths and default directions, with random gaps and stalls
// on both channels; the checker beside the block predicts every vector.
// ----------------------------------------------------------------------------
module sobel_tangent_flow_field_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stff_pkg::*;
	import stff_tb_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic [7:0]         pixel_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] flow_x, flow_y;
	logic [9:0]         out_col;
	logic [11:0]        out_row;
	logic               last_of_frame;

	int mismatches, vectors_due, vectors_checked;
	int tx_idle_pct, rx_idle_pct;
	int items_sent, frames_sent, cycles;
	int last_w, last_h;
	bit hold_req, hold_done;
	int hold_left;

	sobel_tangent_flow_field_top dut (.*);

	stff_flow_checker u_checker (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		logic stall_nxt;
		stall_nxt = ($urandom_range(99) < rx_idle_pct);
		if (hold_left > 0) begin
			stall_nxt = 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			stall_nxt = 1'b1;
			hold_left <= 3000;
			hold_done <= 1'b1;
		end
		out_stall <= stall_nxt;
	end

	task automatic push_item(input logic cmd, input logic [7:0] p);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pixel_value <= p;
		do @(posedge clk); while (in_stall);
		items_sent++;
		// idling phases follow the amount of traffic
		if (items_sent < 320) begin
			tx_idle_pct = 33; rx_idle_pct = 81;
		end else if (items_sent < 640) begin
			tx_idle_pct = 81; rx_idle_pct = 33;
		end else begin
			tx_idle_pct = 0; rx_idle_pct = 0;
		end
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		while (vectors_due != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input int w, input int h, input int s, input int dx, input int dy);
		drain_wait();
		write_reg(REG_FRAME_WIDTH, 16'(w));
		write_reg(REG_FRAME_HEIGHT, 16'(h));
		write_reg(REG_FLOW_STRENGTH, 16'(s));
		write_reg(REG_DEFAULT_DX, 16'(dx));
		write_reg(REG_DEFAULT_DY, 16'(dy));
	endtask

	// pixel pattern of one frame position
	function automatic logic [7:0] pattern_pix(int kind, int r, int c, int a, int b);
		case (kind)
			0: return 8'($urandom);
			1: return 8'(a + ($urandom_range(1)));
			2: return 8'(a + b * c - (b / 2) * r);
			3: return ((c * a + r * b) % 7 > 3) ? 8'd255 : 8'd0;
			default: return ((r + c) % 2) ? 8'd255 : 8'd0;
		endcase
	endfunction

	task automatic send_frame(input int w, input int h, input int kind, input bit mid_flush);
		int a, b;
		a = $urandom_range(255);
		b = $urandom_range(1, 30);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				push_item(CMD_PIXEL, pattern_pix(kind, r, c, a, b));
				if (mid_flush && r == h / 2 && c == 0) push_item(CMD_FLUSH, 8'($urandom));
			end
		end
		frames_sent++;
	endtask

	task automatic flush_all(input int w);
		repeat (w + 1) push_item(CMD_FLUSH, 8'($urandom));
	endtask

	initial begin
		int w, h, s, dx, dy, kind;
		bit carry, mid;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; command = CMD_PIXEL; pixel_value = '0;
		out_stall = 1'b0;
		tx_idle_pct = 33; rx_idle_pct = 81;
		items_sent = 0; frames_sent = 0; cycles = 0;
		hold_req = 0; hold_done = 0; hold_left = 0;
		last_w = 0; last_h = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle flush, one edge frame, zero default direction
		set_geometry(3, 3, 32768, 16384, 0);
		push_item(CMD_FLUSH, 8'hFF);
		send_frame(3, 3, 4, 0);
		flush_all(3);
		set_geometry(3, 3, 16384, 0, 0);
		send_frame(3, 3, 3, 0);
		flush_all(3);

		// strength above one, zero height, zero width and height
		set_geometry(5, 4, 65535, -16384, 16384);
		send_frame(5, 4, 0, 0);
		flush_all(5);
		set_geometry(40, 0, 40000, 0, -16384);
		send_frame(40, 1, 0, 0);
		flush_all(40);
		set_geometry(0, 0, 0, 11585, 11585);
		send_frame(1, 1, 0, 0);
		flush_all(1);
		// tallest frame: a few rows, then force a wrap back to row zero
		set_geometry(3, 8191, 20000, -16384, 0);
		send_frame(3, 3, 2, 0);
		flush_all(3);
		drain_wait();
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		send_frame(3, 3, 0, 0);
		flush_all(3);
		last_w = 3; last_h = 3;

		// random frames
		carry = 0;
		while (items_sent < 950) begin
			if (!carry) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
				h = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
				case ($urandom_range(5))
					0: s = 0;
					1: s = 32768;
					2: s = $urandom_range(32769, 65535);
					default: s = $urandom_range(32768);
				endcase
				dx = $urandom_range(32768) - 16384;
				dy = $urandom_range(32768) - 16384;
				if ($urandom_range(7) == 0) dy = ($urandom_range(1)) ? 16384 : -16384;
				if ($urandom_range(15) == 0) begin
					dx = 0;
					dy = 0;
				end
				set_geometry(w, h, s, dx, dy);
			end
			if (frames_sent == 20) hold_req <= 1'b1;
			kind = $urandom_range(5);
			// mid-frame flush only once the line stores hold this width
			mid = (w == last_w && last_h >= 2 && $urandom_range(7) == 0);
			send_frame(w, h, kind, mid);
			last_w = w; last_h = h;
			carry = ($urandom_range(4) == 0);
			if (!carry) flush_all(w);
		end
		if (carry) flush_all(w);
		in_valid <= 1'b0;

		while (vectors_due != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d frames, %0d input items, %0d vectors compared",
			frames_sent, items_sent, vectors_checked);
		$display("geometry, strength and default direction varied, with stalls and a long hold-off");
		if (mismatches == 0 && vectors_due == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/stff_pkg.sv
rtl/stff_ram.sv
rtl/sobel_tangent_flow_field_top.sv
dv/stff_tb_pkg.sv
dv/stff_flow_checker.sv
dv/sobel_tangent_flow_field_top_tb.sv
